// ===== src/pbrd_pkg.sv =====
// Shared constants for the pulse beat-rate detector.
package pbrd_pkg;

    // Q0.16 coefficient 0.2; 0.8 is formed as 1.0 - 0.2
    localparam int          COEF_BITS = 14;
    localparam logic [13:0] COEF_LO   = 14'd13107;
    localparam int          COEF_SHIFT = 16;

    // rate numerator, milliseconds per minute
    localparam int          NUM_BITS = 16;
    localparam logic [15:0] BPM_NUM  = 16'd60000;

    localparam int          TIME_BITS = 32;
    localparam int          CFG_BITS  = 12;
    localparam int          CFG_IDX_BITS  = 8;
    localparam int          CFG_DATA_BITS = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_BEAT_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_REFRACTORY_MS  = 8'd1;

    localparam logic [CFG_BITS-1:0] THRESHOLD_RST  = 12'd300;
    localparam logic [CFG_BITS-1:0] REFRACTORY_RST = 12'd250;

endpackage

// ===== src/pbrd_cmul.sv =====
// Bit-serial multiplier of a signed operand by the constant coefficient.
module pbrd_cmul
    import pbrd_pkg::*;
#(
    parameter int DW = 22
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [DW-1:0]        operand,
    output logic                        done,
    output logic signed [DW+COEF_BITS-1:0] product
);

    localparam int PW = DW + COEF_BITS;
    localparam int CW = $clog2(COEF_BITS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [DW-1:0] opd_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] acc_next;

    // MSB-first shift-add over the coefficient bits
    always_comb
    begin
        acc_next = acc_reg <<< 1;
        if (COEF_LO[cnt_reg])
        begin
            acc_next = acc_next + PW'(opd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(COEF_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            opd_reg <= operand;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== src/pbrd_div.sv =====
// Restoring divider: constant numerator by a 32-bit divisor, one quotient bit a cycle.
module pbrd_div
    import pbrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [TIME_BITS-1:0] divisor,
    output logic                 done,
    output logic [NUM_BITS-1:0]  quotient
);

    localparam int CW = $clog2(NUM_BITS);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [TIME_BITS-1:0]  div_reg;
    logic [TIME_BITS-1:0]  rem_reg;
    logic [NUM_BITS-1:0]   quo_reg;
    logic [TIME_BITS:0]    trial;
    logic [TIME_BITS:0]    diff;
    logic                  qbit;

    always_comb
    begin
        trial = {rem_reg, BPM_NUM[cnt_reg]};
        diff  = trial - {1'b0, div_reg};
        qbit  = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits in 32 bits
            rem_reg <= qbit ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            quo_reg <= {quo_reg[NUM_BITS-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/pulse_beat_rate_detector_core.sv =====
// Top level of the pulse beat-rate detector.
//
// Input words on s_axis carry one sensor sample and its millisecond time.
// Each word runs two exponential filters (DC tracker at 0.8, smoother at 0.2
// on the previous output) through one shared bit-serial coefficient
// multiplier. When the smoothed level is above beat_threshold and more than
// refractory_ms has passed since the last beat, a serial divider forms
// 60000 / elapsed ms and one word goes out on m_axis; otherwise the sample
// gives no output word.
// The block finishes one input word before it takes the next: s_axis_tready
// is high only between words.
// The output word sits in its own register, so the next sample is accepted
// while a rate waits; a stalled receiver only holds the block at the point
// where a new rate must be pushed out.
// cfg writes are taken every cycle (cfg_ready tied high); write only while
// idle. Unknown indexes are dropped, data is masked to 12 bits.
// Reset clears filter states and last-beat time, loads threshold 300 and
// refractory 250 ms.
module pulse_beat_rate_detector_core
    import pbrd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 8,
    localparam int IN_W = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_W-1:0]          s_axis_tdata,   // sample, now_ms, zero pad
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [NUM_BITS-1:0]      m_axis_tdata,   // beats_per_minute
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int LW   = SAMPLE_BITS + FRAC_BITS;   // lowpass, unsigned
    localparam int BW   = LW + 1;                    // highpass/bandpass, signed
    localparam int DW   = LW + 2;                    // multiplier operand
    localparam int PW   = DW + COEF_BITS;
    localparam int CMPW = ((BW > CFG_BITS + FRAC_BITS) ? BW : CFG_BITS + FRAC_BITS) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LP_GO = 3'd1;
    localparam logic [2:0] S_LP_WT = 3'd2;
    localparam logic [2:0] S_BP_GO = 3'd3;
    localparam logic [2:0] S_BP_WT = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;
    localparam logic [2:0] S_DIV_WT = 3'd6;
    localparam logic [2:0] S_PUSH  = 3'd7;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [LW-1:0]          lp_reg;
    logic signed [BW-1:0]   bp_reg;
    logic signed [BW-1:0]   hp_reg;
    logic [TIME_BITS-1:0]   last_beat_reg;
    logic [CFG_BITS-1:0]    thr_reg;
    logic [CFG_BITS-1:0]    refr_reg;
    logic                   out_valid_reg;
    logic [NUM_BITS-1:0]    out_data_reg;

    logic                   in_acc;
    logic                   out_free;
    logic [LW-1:0]          scaled;
    logic signed [DW-1:0]   mul_opd;
    logic                   mul_start;
    logic                   mul_done;
    logic signed [PW-1:0]   mul_prod;
    logic signed [PW-1:0]   lp_sum;
    logic [LW-1:0]          lp_new;
    logic signed [BW-1:0]   hp_new;
    logic signed [PW-1:0]   bp_sum;
    logic [TIME_BITS-1:0]   elapsed;
    logic                   over_thr;
    logic                   past_refr;
    logic                   beat;
    logic                   div_start;
    logic                   div_done;
    logic [NUM_BITS-1:0]    div_quo;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign scaled    = {sample_reg, {FRAC_BITS{1'b0}}};
    assign cfg_ready = 1'b1;

    // lowpass' = L + floor(0.2 * (S - L)), highpass = S - lowpass'
    assign lp_sum = $signed({{(PW - LW){1'b0}}, lp_reg}) + (mul_prod >>> COEF_SHIFT);
    assign lp_new = lp_sum[LW-1:0];
    assign hp_new = $signed({1'b0, scaled}) - $signed({1'b0, lp_new});

    // bandpass' = H + floor(0.2 * (B - H))
    assign bp_sum = PW'(hp_reg) + (mul_prod >>> COEF_SHIFT);

    always_comb
    begin
        if (state_reg == S_LP_GO)
        begin
            mul_opd = $signed({2'b00, scaled}) - $signed({2'b00, lp_reg});
        end
        else
        begin
            mul_opd = DW'(bp_reg) - DW'(hp_reg);
        end
    end

    assign mul_start = (state_reg == S_LP_GO) || (state_reg == S_BP_GO);

    pbrd_cmul #(.DW(DW)) u_cmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (mul_opd),
        .done    (mul_done),
        .product (mul_prod)
    );

    // beat test on the updated bandpass level
    assign elapsed   = now_reg - last_beat_reg;
    assign over_thr  = !bp_reg[BW-1] &&
                       (CMPW'(bp_reg[BW-2:0]) > CMPW'({thr_reg, {FRAC_BITS{1'b0}}}));
    assign past_refr = elapsed > TIME_BITS'(refr_reg);
    assign beat      = over_thr && past_refr;
    assign div_start = (state_reg == S_DECIDE) && beat;

    pbrd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (elapsed),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_acc) state_next = S_LP_GO;
            S_LP_GO:  state_next = S_LP_WT;
            S_LP_WT:  if (mul_done) state_next = S_BP_GO;
            S_BP_GO:  state_next = S_BP_WT;
            S_BP_WT:  if (mul_done) state_next = S_DECIDE;
            S_DECIDE: state_next = beat ? S_DIV_WT : S_IDLE;
            S_DIV_WT: if (div_done) state_next = S_PUSH;
            S_PUSH:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lp_reg        <= '0;
            bp_reg        <= '0;
            last_beat_reg <= '0;
            thr_reg       <= THRESHOLD_RST;
            refr_reg      <= REFRACTORY_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_BEAT_THRESHOLD)
                begin
                    thr_reg <= cfg_data[CFG_BITS-1:0];
                end
                else if (cfg_index == REG_REFRACTORY_MS)
                begin
                    refr_reg <= cfg_data[CFG_BITS-1:0];
                end
            end
            if (state_reg == S_LP_WT && mul_done)
            begin
                lp_reg <= lp_new;
            end
            if (state_reg == S_BP_WT && mul_done)
            begin
                bp_reg <= bp_sum[BW-1:0];
            end
            if (state_reg == S_PUSH && out_free)
            begin
                last_beat_reg <= now_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            now_reg    <= s_axis_tdata[SAMPLE_BITS +: TIME_BITS];
        end
        if (state_reg == S_LP_WT && mul_done)
        begin
            hp_reg <= hp_new;
        end
        if (state_reg == S_PUSH && out_free)
        begin
            out_data_reg <= div_quo;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== src/pbrd_checker.sv =====
// Port-level checks for the pulse beat-rate detector, bound to the top level.
module pbrd_checker
    import pbrd_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [NUM_BITS-1:0]      m_axis_tdata
);

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // rate can never exceed the numerator
    a_rate_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata <= BPM_NUM)
        else $error("rate above 60000");

    // one word at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input ready right after accept");

    // no result can come out of the cycle following an accept
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !$rose(m_axis_tvalid))
        else $error("output word too soon after accept");

endmodule

bind pulse_beat_rate_detector_core pbrd_checker u_pbrd_checker (.*);

// ===== test/tb_pulse_beat_rate_detector_core.sv =====
// Testbench for pulse_beat_rate_detector_core: filter and beat-rate predictor with scoreboard.
module tb_pulse_beat_rate_detector_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pbrd_pkg::*;

    localparam int          IN_W          = 48;
    localparam longint      DC_KEEP       = 52429;   // 0.8 in Q0.16
    localparam longint      DC_TAKE       = 13107;   // 0.2 in Q0.16
    localparam int          FRAC          = 8;
    localparam logic [31:0] MS_PER_MIN    = 32'd60000;
    localparam int          SETTLE_CYCLES = 100;     // lets a word in flight finish
    localparam int          MAX_REPORTS   = 40;
    localparam int          PHASE_ITEMS   = 228;

    // Predictor of the two filters and the beat timer, plus the queue of rates
    // still owed by the block.
    class beat_rate_scoreboard;
        logic [19:0]        dc_level;
        logic signed [20:0] smooth_level;
        logic [31:0]        last_beat_ms;
        logic [11:0]        beat_threshold;
        logic [11:0]        refractory_ms;
        logic [15:0]        expected_bpm[$];
        int                 mismatches;

        function new();
            dc_level       = '0;
            smooth_level   = '0;
            last_beat_ms   = '0;
            beat_threshold = THRESHOLD_RST;
            refractory_ms  = REFRACTORY_RST;
            mismatches     = 0;
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_BEAT_THRESHOLD)
                beat_threshold = data[11:0];
            else if (idx == REG_REFRACTORY_MS)
                refractory_ms = data[11:0];
        endfunction

        function void note_sample(logic [11:0] sample, logic [31:0] now_ms);
            longint      scaled;
            longint      highpass;
            longint      acc;
            logic [31:0] elapsed;
            scaled = longint'(sample) << FRAC;
            // DC tracker, floor by 16 bits
            acc = DC_KEEP * longint'(dc_level) + DC_TAKE * scaled;
            dc_level = 20'(acc >>> 16);
            highpass = scaled - longint'(dc_level);
            // smoother on the DC-free signal; arithmetic shift gives floor
            acc = DC_TAKE * longint'(smooth_level) + DC_KEEP * highpass;
            smooth_level = 21'(acc >>> 16);
            elapsed = now_ms - last_beat_ms;     // wraps mod 2^32
            if (longint'(smooth_level) > (longint'(beat_threshold) << FRAC) &&
                elapsed > 32'(refractory_ms))
            begin
                expected_bpm.push_back(16'(MS_PER_MIN / elapsed));
                last_beat_ms = now_ms;
            end
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_REPORTS)
                $display("%0t mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_bpm(logic [15:0] got);
            logic [15:0] want;
            if (expected_bpm.size() == 0)
                report_mismatch($sformatf("unexpected beats_per_minute %0d", got));
            else
            begin
                want = expected_bpm.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("beats_per_minute %0d, want %0d", got, want));
            end
        endtask

        task check_drained();
            if (expected_bpm.size() != 0)
                report_mismatch($sformatf("%0d beat rates never came out",
                                          expected_bpm.size()));
        endtask
    endclass

    logic                     clk;
    logic                     rst_n         = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_W-1:0]          s_axis_tdata  = '0;    // sample, now_ms, zero pad
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [NUM_BITS-1:0]      m_axis_tdata;          // beats_per_minute
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data      = '0;

    beat_rate_scoreboard sb;
    bit                  steady = 1'b0;            // no idling on either side
    logic [31:0]         sensor_clock_ms;

    pulse_beat_rate_detector_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stalls about a quarter of the cycles unless in the steady stretch.
    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 25);

    // Output monitor: every accepted word is checked against the oldest rate owed.
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_bpm(m_axis_tdata);

    // One sample word. Valid stays high into the next word unless a gap is taken,
    // so it never gets two assignments in the same step. Gap lengths vary enough
    // to land on every stage of the block's work.
    task send_sample(input logic [11:0] sample, input logic [31:0] now_ms);
        int gap;
        if (!steady && $urandom_range(0, 99) < 25)
        begin
            gap = $urandom_range(1, 70);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {4'b0, now_ms, sample};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_sample(sample, now_ms);
    endtask

    // Wait for every owed rate, then let a possible no-beat word finish.
    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_bpm.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(idx, data);
    endtask

    // Both registers plus one write to an unused index, back to back.
    task apply_settings(input logic [CFG_DATA_BITS-1:0] thr_word,
                        input logic [CFG_DATA_BITS-1:0] refr_word,
                        input logic [CFG_IDX_BITS-1:0]  junk_idx,
                        input logic [CFG_DATA_BITS-1:0] junk_word);
        write_reg(REG_BEAT_THRESHOLD, thr_word);
        write_reg(REG_REFRACTORY_MS, refr_word);
        write_reg(junk_idx, junk_word);
        cfg_valid <= 1'b0;
    endtask

    // Mostly pulse-shaped trains (baseline with a short peak each period) with a
    // steady sample interval; some noise and rail-to-rail bursts, and time that
    // sometimes jumps, runs backward or lands near the wrap point.
    task run_beat_phase(input int n_items);
        int pos;
        int period;
        int base;
        int amp;
        int step_ms;
        int shape;
        int level;
        int pick;
        pos    = 0;
        period = 1;
        base   = 0;
        amp    = 0;
        step_ms = 20;
        shape  = 0;
        for (int i = 0; i < n_items; i++)
        begin
            if (pos == 0)
            begin
                shape   = $urandom_range(0, 9);
                period  = $urandom_range(3, 50);
                base    = $urandom_range(0, 2500);
                amp     = $urandom_range(200, 4095);
                step_ms = $urandom_range(0, 40);
            end
            if (shape < 7)
                level = (pos < 2) ? base + amp : base + $urandom_range(0, 60);
            else if (shape < 9)
                level = $urandom_range(0, 4095);
            else
                level = $urandom_range(0, 1) ? 4095 : 0;
            if (level > 4095)
                level = 4095;
            pos = (pos + 1) % period;

            pick = $urandom_range(0, 99);
            if (pick < 90)
                sensor_clock_ms = sensor_clock_ms + step_ms + $urandom_range(0, 3);
            else if (pick < 94)
                sensor_clock_ms = sensor_clock_ms + $urandom_range(0, 5000);
            else if (pick < 96)
                sensor_clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            else if (pick < 98)
                sensor_clock_ms = $urandom;
            else
                sensor_clock_ms = sensor_clock_ms - $urandom_range(0, 500);
            send_sample(12'(level), sensor_clock_ms);
        end
    endtask

    initial
    begin
        logic [11:0] thr;
        logic [11:0] refr;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: threshold 300, refractory 250 ms.
        // First beat is timed from zero.
        send_sample(12'd0, 32'd0);
        send_sample(12'd0, 32'd20);
        send_sample(12'd4095, 32'd1000);
        send_sample(12'd4095, 32'd1010);       // inside refractory window
        send_sample(12'd0, 32'd1020);          // swing negative
        send_sample(12'd0, 32'd1040);
        send_sample(12'd4095, 32'd1300);
        // time wrap: a huge elapsed time gives rate zero, then across 2^32
        send_sample(12'd0, 32'hFFFF_FF00);
        send_sample(12'd4095, 32'hFFFF_FFF0);
        send_sample(12'd0, 32'hFFFF_FFFF);
        send_sample(12'd0, 32'd0);
        send_sample(12'd4095, 32'd600);
        send_sample(12'd2048, 32'd700);
        send_sample(12'd4095, 32'd701);
        drain();

        // Zero threshold and zero refractory; upper data bits must be masked off.
        apply_settings(16'hF000, 16'h5000, 8'hFF, 16'hFFFF);
        send_sample(12'd0, 32'd2000);
        send_sample(12'd4095, 32'd2100);
        send_sample(12'd4095, 32'd2100);       // zero elapsed never counts
        send_sample(12'd4095, 32'd2101);       // one millisecond: top rate
        send_sample(12'd4095, 32'd2102);
        drain();

        // Both registers at their top value.
        apply_settings(16'hFFFF, 16'h0FFF, REG_REFRACTORY_MS + 8'd1, 16'h0001);
        send_sample(12'd0, 32'd3000);
        send_sample(12'd4095, 32'd9000);
        send_sample(12'd0, 32'd9001);
        send_sample(12'd4095, 32'hFFFF_FFFF);
        drain();

        sensor_clock_ms = 32'd10000;
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: thr = 12'($urandom_range(0, 1500));
                1: thr = 12'd0;
                2: thr = 12'($urandom_range(0, 400));
                default: thr = 12'($urandom_range(100, 900));
            endcase
            if (p == 5)
                thr = 12'd4095;
            if (p == 1)
                refr = 12'd0;
            else if (p == 6)
                refr = 12'd4095;
            else
                refr = 12'($urandom_range(0, 800));
            apply_settings({4'($urandom), thr}, {4'($urandom), refr},
                           8'($urandom_range(REG_REFRACTORY_MS + 1, 255)),
                           16'($urandom));
            steady = (p == 3);
            run_beat_phase(PHASE_ITEMS);
            drain();
        end

        sb.check_drained();
        if (sb.mismatches == 0)
            $display("[pulse_beat_rate_detector_core] OK");
        else
            $display("[pulse_beat_rate_detector_core] ERROR");
        $finish;
    end

    // Watchdog: a correct run needs well under a fifth of this.
    initial
    begin
        #10_000_000;
        $display("[pulse_beat_rate_detector_core] ERROR");
        $finish;
    end

endmodule
